// ===== design/standardized_genotype_matvec_accum_macros.svh =====
// assertion macros shared by the checker
`ifndef STANDARDIZED_GENOTYPE_MATVEC_ACCUM_MACROS_SVH
`define STANDARDIZED_GENOTYPE_MATVEC_ACCUM_MACROS_SVH

// same-cycle implication
`define SGM_ASSERT_SAME(lbl, clk, dis, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SGM_ASSERT_NEXT(lbl, clk, dis, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/sgm_pkg.sv =====
// ----------------------------------------------------------------------------
// sgm_pkg
// shared types, codes and constants of the genotype matrix-vector accumulator
// ----------------------------------------------------------------------------
package sgm_pkg;

    localparam int DEF_MAX_INDIVIDUALS = 4096;
    localparam int DEF_MAX_COMPONENTS  = 8;

    localparam int               COUNT_W     = 13;
    localparam logic [12:0]      COUNT_RESET = 13'd4096;
    localparam logic [0:0]       REG_COUNT   = 1'b0;

    localparam logic [19:0]      SD_ONE      = 20'd65536;

    // divider geometry: 54-bit dividend, 20-bit divisor, two quotient bits a cycle
    localparam int DIVD_W     = 54;
    localparam int DIVS_W     = 20;
    localparam int REM_W      = 21;
    localparam int DIV_ITERS  = DIVD_W / 2;
    localparam int DIV_CNT_W  = 5;

    typedef enum logic [1:0] {
        ACT_ACCUM = 2'd0,
        ACT_READ  = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        S_INIT_CLR,
        S_IDLE,
        S_DISPATCH,
        S_LANE,
        S_MUL,
        S_DIV_START,
        S_DIV_WAIT,
        S_MEM_RD,
        S_MEM_WR,
        S_RD_ISSUE,
        S_CLR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic load;
        logic lane_inc;
        logic mul_en;
        logic div_start;
        logic mem_rd;
        logic mem_wr;
        logic sweep_wr;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic    in_valid;
        t_action action;
        logic    lane_ok;
        logic    lane_last;
        logic    div_busy;
        logic    sweep_last;
        logic    out_free;
    } t_status;

endpackage

// ===== design/sgm_ctrl.sv =====
// ----------------------------------------------------------------------------
// sgm_ctrl
// sequencer: walks one item through lanes, divider and memory
// ----------------------------------------------------------------------------
module sgm_ctrl
    import sgm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT_CLR: begin
                if (i_status.sweep_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_status.in_valid) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                unique case (i_status.action)
                    ACT_ACCUM: n_state = S_LANE;
                    ACT_READ:  n_state = S_RD_ISSUE;
                    ACT_CLEAR: n_state = S_CLR;
                    default:   n_state = S_DONE;
                endcase
            end
            S_LANE: begin
                if (i_status.lane_ok) n_state = S_MUL;
                else if (i_status.lane_last) n_state = S_DONE;
            end
            S_MUL:       n_state = S_DIV_START;
            S_DIV_START: n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (!i_status.div_busy) n_state = S_MEM_RD;
            end
            S_MEM_RD:    n_state = S_MEM_WR;
            S_MEM_WR: begin
                n_state = i_status.lane_last ? S_DONE : S_LANE;
            end
            S_RD_ISSUE:  n_state = S_DONE;
            S_CLR: begin
                if (i_status.sweep_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_INIT_CLR:  o_cmd.sweep_wr = 1'b1;
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.load     = i_status.in_valid;
            end
            S_LANE: begin
                o_cmd.lane_inc = !i_status.lane_ok && !i_status.lane_last;
            end
            S_MUL:       o_cmd.mul_en    = 1'b1;
            S_DIV_START: o_cmd.div_start = 1'b1;
            S_MEM_RD:    o_cmd.mem_rd    = 1'b1;
            S_MEM_WR: begin
                o_cmd.mem_wr   = 1'b1;
                o_cmd.lane_inc = !i_status.lane_last;
            end
            S_RD_ISSUE:  o_cmd.mem_rd   = 1'b1;
            S_CLR:       o_cmd.sweep_wr = 1'b1;
            S_DONE:      o_cmd.out_load = i_status.out_free;
            default:     o_cmd = '0;
        endcase
    end

endmodule

// ===== design/sgm_div.sv =====
// ----------------------------------------------------------------------------
// sgm_div
// unsigned restoring divider, two quotient bits per cycle
// ----------------------------------------------------------------------------
module sgm_div
    import sgm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIVD_W-1:0] i_dividend,
    input  logic [DIVS_W-1:0] i_divisor,
    output logic              o_busy,
    output logic [DIVD_W-1:0] o_quotient
);

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIVD_W-1:0]    r_quo;
    logic [REM_W-1:0]     r_rem;
    logic [DIVS_W-1:0]    r_div;

    logic [REM_W-1:0]     w_rem_a, w_rem_a2, w_rem_b, w_rem_b2;
    logic [DIVD_W-1:0]    w_quo_a, w_quo_b;
    logic                 w_ge_a, w_ge_b;

    // quotient bits shift in from the bottom as dividend bits leave the top
    always_comb begin
        w_rem_a  = {r_rem[REM_W-2:0], r_quo[DIVD_W-1]};
        w_ge_a   = w_rem_a >= {1'b0, r_div};
        w_rem_a2 = w_ge_a ? (w_rem_a - {1'b0, r_div}) : w_rem_a;
        w_quo_a  = {r_quo[DIVD_W-2:0], w_ge_a};
        w_rem_b  = {w_rem_a2[REM_W-2:0], w_quo_a[DIVD_W-1]};
        w_ge_b   = w_rem_b >= {1'b0, r_div};
        w_rem_b2 = w_ge_b ? (w_rem_b - {1'b0, r_div}) : w_rem_b;
        w_quo_b  = {w_quo_a[DIVD_W-2:0], w_ge_b};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_ITERS - 1)) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= w_quo_b;
            r_rem <= w_rem_b2;
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

// ===== design/sgm_dp.sv =====
// ----------------------------------------------------------------------------
// sgm_dp
// item registers, lane arithmetic, accumulator memory and output register
// ----------------------------------------------------------------------------
module sgm_dp
    import sgm_pkg::*;
#(
    parameter int MAX_INDIVIDUALS = DEF_MAX_INDIVIDUALS,
    parameter int MAX_COMPONENTS  = DEF_MAX_COMPONENTS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  logic               i_in_valid,
    input  logic [COUNT_W-1:0] i_count,
    input  logic [1:0]         i_action,
    input  logic [2:0]         i_component,
    input  logic [9:0]         i_byte_index,
    input  logic [7:0]         i_packed_byte,
    input  logic signed [31:0] i_weight,
    input  logic [17:0]        i_snp_mean,
    input  logic [19:0]        i_snp_sd,
    input  logic [11:0]        i_read_individual,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic signed [63:0] o_read_value,
    output logic               o_is_read
);

    localparam int DEPTH  = MAX_COMPONENTS * MAX_INDIVIDUALS;
    localparam int ADDR_W = $clog2(DEPTH);

    t_action           r_action;
    logic [2:0]        r_comp;
    logic [9:0]        r_bidx;
    logic [7:0]        r_pbyte;
    logic              r_wneg;
    logic [31:0]       r_wmag;
    logic [17:0]       r_mean;
    logic [19:0]       r_sd;
    logic [11:0]       r_ridx;
    logic [1:0]        r_lane;
    logic [49:0]       r_prod;
    logic              r_neg;
    logic [ADDR_W-1:0] r_sweep;
    logic [63:0]       r_rdata;
    logic [63:0]       r_mem [DEPTH];
    logic              r_out_valid;
    logic [63:0]       r_out_value;
    logic              r_out_is_read;

    logic [1:0]        w_code;
    logic [11:0]       w_ind;
    logic              w_comp_ok;
    logic              w_ind_ok;
    logic              w_rd_ok;
    logic [17:0]       w_num;
    logic              w_nneg;
    logic [17:0]       w_nmag;
    logic [49:0]       w_prod;
    logic [DIVD_W-1:0] w_dividend;
    logic              w_div_busy;
    logic [DIVD_W-1:0] w_quo;
    logic [63:0]       w_q64;
    logic [63:0]       w_term;
    logic [ADDR_W-1:0] w_laddr;
    logic [ADDR_W-1:0] w_raddr;
    logic [ADDR_W-1:0] w_rd_addr;
    logic              w_sweep_last;
    logic              w_out_free;

    always_comb begin
        w_code    = 2'(r_pbyte >> {r_lane, 1'b0});
        w_ind     = {r_bidx, r_lane};
        w_comp_ok = 32'(r_comp) < 32'(MAX_COMPONENTS);
        w_ind_ok  = (32'(w_ind) < 32'(i_count)) && (32'(w_ind) < 32'(MAX_INDIVIDUALS));
        w_rd_ok   = w_comp_ok && (32'(r_ridx) < 32'(MAX_INDIVIDUALS));
        w_num     = {w_code, 16'd0};
        w_nneg    = r_mean > w_num;
        w_nmag    = w_nneg ? (r_mean - w_num) : (w_num - r_mean);
        w_prod    = r_wmag * w_nmag;
        // times four for Q.32, plus half the divisor to round to nearest
        w_dividend = {2'b00, r_prod, 2'b00} + DIVD_W'(r_sd >> 1);
        w_q64     = 64'(w_quo);
        w_term    = r_neg ? (64'd0 - w_q64) : w_q64;
        w_laddr   = ADDR_W'(32'(r_comp) * 32'(MAX_INDIVIDUALS) + 32'(w_ind));
        w_raddr   = ADDR_W'(32'(r_comp) * 32'(MAX_INDIVIDUALS) + 32'(r_ridx));
        w_rd_addr = (r_action == ACT_READ) ? w_raddr : w_laddr;
        w_sweep_last = 32'(r_sweep) == 32'(DEPTH - 1);
        w_out_free   = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= t_action'(i_action);
            r_comp   <= i_component;
            r_bidx   <= i_byte_index;
            r_pbyte  <= i_packed_byte;
            r_wneg   <= i_weight[31];
            r_wmag   <= i_weight[31] ? (32'd0 - $unsigned(i_weight)) : $unsigned(i_weight);
            r_mean   <= i_snp_mean;
            r_sd     <= (i_snp_sd == 20'd0) ? SD_ONE : i_snp_sd;
            r_ridx   <= i_read_individual;
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_prod;
            r_neg  <= r_wneg ^ w_nneg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane      <= '0;
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) r_lane <= '0;
            else if (i_cmd.lane_inc) r_lane <= r_lane + 1'b1;
            if (i_cmd.sweep_wr) r_sweep <= w_sweep_last ? '0 : r_sweep + 1'b1;
            if (i_cmd.out_load) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    // accumulator store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep_wr) begin
            r_mem[r_sweep] <= 64'd0;
        end else if (i_cmd.mem_wr) begin
            r_mem[w_laddr] <= r_rdata + w_term;
        end
        if (i_cmd.mem_rd) r_rdata <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_is_read <= (r_action == ACT_READ);
            r_out_value   <= ((r_action == ACT_READ) && w_rd_ok) ? r_rdata : 64'd0;
        end
    end

    sgm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_sd),
        .o_busy     (w_div_busy),
        .o_quotient (w_quo)
    );

    assign o_status.in_valid   = i_in_valid;
    assign o_status.action     = r_action;
    assign o_status.lane_ok    = w_comp_ok && w_ind_ok && (w_code != 2'd3);
    assign o_status.lane_last  = r_lane == 2'd3;
    assign o_status.div_busy   = w_div_busy;
    assign o_status.sweep_last = w_sweep_last;
    assign o_status.out_free   = w_out_free;

    assign o_out_valid  = r_out_valid;
    assign o_read_value = $signed(r_out_value);
    assign o_is_read    = r_out_is_read;

endmodule

// ===== design/standardized_genotype_matvec_accum.sv =====
// ----------------------------------------------------------------------------
// standardized_genotype_matvec_accum
// accumulates weighted standardized genotypes per individual and component
// ----------------------------------------------------------------------------
// input channel i_valid/o_ready carries one item: accumulate a packed byte,
// read one accumulator, clear the store or do nothing; output channel
// o_valid/i_ready returns one item per input item (read_value, is_read)
// one item is in work at a time; o_ready rises again once the result sits in
// the output register, so a new item can enter while the receiver stalls
// accumulate: each lane in use passes through multiply, radix-4 divider and
// memory read-modify-write; lanes not in use are skipped
// read: one registered read of the accumulator memory port
// clear: one memory entry per cycle, MAX_COMPONENTS * MAX_INDIVIDUALS entries
// reset starts the same clearing pass over the whole store;
// o_ready stays low until it ends, config writes are taken throughout
// a stalled result holds in the output register; the next result waits
// behind it
// individual_count at byte address 0 of the APB port, reset value 4096
// ----------------------------------------------------------------------------
module standardized_genotype_matvec_accum
    import sgm_pkg::*;
#(
    parameter int MAX_INDIVIDUALS = DEF_MAX_INDIVIDUALS,
    parameter int MAX_COMPONENTS  = DEF_MAX_COMPONENTS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_action,
    input  logic [2:0]         i_component,
    input  logic [9:0]         i_byte_index,
    input  logic [7:0]         i_packed_byte,
    input  logic signed [31:0] i_weight,
    input  logic [17:0]        i_snp_mean,
    input  logic [19:0]        i_snp_sd,
    input  logic [11:0]        i_read_individual,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [63:0] o_read_value,
    output logic               o_is_read
);

    logic [COUNT_W-1:0] r_count;
    logic [0:0]         w_index;
    logic               w_wr;
    t_cmd               w_cmd;
    t_status            w_status;

    assign w_index = paddr[2];
    assign w_wr    = psel && penable && pwrite && pready && (w_index == REG_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_RESET;
        end else if (w_wr) begin
            r_count <= pwdata[COUNT_W-1:0];
        end
    end

    assign prdata = (w_index == REG_COUNT) ? 32'(r_count) : 32'd0;
    assign pready = 1'b1;

    sgm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    sgm_dp #(
        .MAX_INDIVIDUALS (MAX_INDIVIDUALS),
        .MAX_COMPONENTS  (MAX_COMPONENTS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_in_valid        (i_valid),
        .i_count           (r_count),
        .i_action          (i_action),
        .i_component       (i_component),
        .i_byte_index      (i_byte_index),
        .i_packed_byte     (i_packed_byte),
        .i_weight          (i_weight),
        .i_snp_mean        (i_snp_mean),
        .i_snp_sd          (i_snp_sd),
        .i_read_individual (i_read_individual),
        .i_out_ready       (i_ready),
        .o_out_valid       (o_valid),
        .o_read_value      (o_read_value),
        .o_is_read         (o_is_read)
    );

    assign o_ready = w_cmd.in_ready;

endmodule

// ===== design/sgm_checker.sv =====
// ----------------------------------------------------------------------------
// sgm_checker
// port-level checks of the accumulator, bound to the top level
// ----------------------------------------------------------------------------
`include "standardized_genotype_matvec_accum_macros.svh"

module sgm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [63:0] o_read_value,
    input logic               o_is_read
);

    // a stalled result holds
    `SGM_ASSERT_NEXT(a_out_hold, i_clk, !i_rst_n, o_valid && !i_ready,
        o_valid && $stable(o_read_value) && $stable(o_is_read), "output changed while stalled")

    // non-read items carry a zero value
    `SGM_ASSERT_SAME(a_zero_value, i_clk, !i_rst_n, o_valid && !o_is_read,
        o_read_value == 64'sd0, "non-read item with nonzero value")

    // one item in work at a time
    `SGM_ASSERT_NEXT(a_one_item, i_clk, !i_rst_n, i_valid && o_ready,
        !o_ready, "item accepted while another in work")

    // reset empties the output register
    `SGM_ASSERT_NEXT(a_reset_out, i_clk, 1'b0, !i_rst_n,
        !o_valid, "output valid after reset")

endmodule

bind standardized_genotype_matvec_accum sgm_checker u_sgm_checker (.*);

// ===== verif/standardized_genotype_matvec_accum_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// standardized_genotype_matvec_accum_checker
// watches the register port and both item channels, keeps its own copy of the
// accumulator store and compares every returned item with the oldest
// predicted one
// ----------------------------------------------------------------------------
module standardized_genotype_matvec_accum_checker
    import sgm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    input  logic               i_valid,
    input  logic               o_ready,
    input  logic [1:0]         i_action,
    input  logic [2:0]         i_component,
    input  logic [9:0]         i_byte_index,
    input  logic [7:0]         i_packed_byte,
    input  logic signed [31:0] i_weight,
    input  logic [17:0]        i_snp_mean,
    input  logic [19:0]        i_snp_sd,
    input  logic [11:0]        i_read_individual,
    input  logic               o_valid,
    input  logic               i_ready,
    input  logic signed [63:0] o_read_value,
    input  logic               o_is_read,
    output int                 fail_count,
    output int                 pending
);

    typedef struct packed {
        logic [63:0] value;
        logic        is_read;
    } t_answer;

    logic [63:0]  sum_store [int];
    logic [12:0]  count_reg;
    t_answer      answers [$];

    // rounded weight * (g - mean) / sd in Q.32, ties away from zero
    function automatic logic [63:0] std_term(logic [1:0] code, logic [31:0] w,
                                             logic [17:0] mean, logic [19:0] sd_in);
        logic        wneg;
        logic        nneg;
        logic [63:0] wmag;
        logic [63:0] num;
        logic [63:0] nmag;
        logic [63:0] sd;
        logic [63:0] q;
        wneg = w[31];
        wmag = wneg ? (64'h1_0000_0000 - {32'b0, w}) : {32'b0, w};
        num  = 64'(code) * 64'd65536;
        nneg = 64'(mean) > num;
        nmag = nneg ? (64'(mean) - num) : (num - 64'(mean));
        sd   = (sd_in == 20'd0) ? 64'(SD_ONE) : 64'(sd_in);
        q    = (wmag * nmag * 64'd4 + sd / 64'd2) / sd;
        return (wneg != nneg) ? -q : q;
    endfunction

    function automatic t_answer apply_item();
        t_answer     a;
        int          limit;
        int          ind;
        int          key;
        logic [1:0]  code;
        a = '0;
        limit = (count_reg > 13'd4096) ? 4096 : int'(count_reg);
        case (t_action'(i_action))
            ACT_ACCUM: begin
                for (int lane = 0; lane < 4; lane++) begin
                    ind  = int'(i_byte_index) * 4 + lane;
                    code = i_packed_byte[2*lane +: 2];
                    if (ind < limit && code != 2'd3) begin
                        key = int'(i_component) * DEF_MAX_INDIVIDUALS + ind;
                        if (!sum_store.exists(key))
                            sum_store[key] = '0;
                        sum_store[key] += std_term(code, i_weight, i_snp_mean, i_snp_sd);
                    end
                end
            end
            ACT_READ: begin
                a.is_read = 1'b1;
                key = int'(i_component) * DEF_MAX_INDIVIDUALS + int'(i_read_individual);
                if (sum_store.exists(key))
                    a.value = sum_store[key];
            end
            ACT_CLEAR: begin
                sum_store.delete();
            end
            default: ;
        endcase
        return a;
    endfunction

    initial begin
        fail_count = 0;
        pending    = 0;
        count_reg  = COUNT_RESET;
    end

    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n) begin
            // returned item first: it can never belong to an item taken this cycle
            if (o_valid && i_ready) begin
                if (answers.size() == 0) begin
                    $error("unexpected item: read_value %0d is_read %0b",
                           o_read_value, o_is_read);
                    fail_count++;
                end else begin
                    want = answers.pop_front();
                    if (o_read_value !== want.value) begin
                        $error("read_value: expected %0d, got %0d",
                               $signed(want.value), o_read_value);
                        fail_count++;
                    end
                    if (o_is_read !== want.is_read) begin
                        $error("is_read: expected %0b, got %0b", want.is_read, o_is_read);
                        fail_count++;
                    end
                end
            end
            if (i_valid && o_ready)
                answers.push_back(apply_item());
            if (psel && penable && pwrite && pready && paddr == {REG_COUNT, 2'b00})
                count_reg <= pwdata[12:0];
            pending <= answers.size();
        end
    end

endmodule

// ===== verif/tb_standardized_genotype_matvec_accum.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_standardized_genotype_matvec_accum
// drives accumulate, read, clear and no-op items under several idling mixes and
// individual counts; the checker predicts and compares every returned item
// ----------------------------------------------------------------------------
module tb_standardized_genotype_matvec_accum;
    import sgm_pkg::*;

    localparam int QUIET_LIMIT = 200000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [1:0]         i_action = ACT_NONE;
    logic [2:0]         i_component = '0;
    logic [9:0]         i_byte_index = '0;
    logic [7:0]         i_packed_byte = '0;
    logic signed [31:0] i_weight = '0;
    logic [17:0]        i_snp_mean = '0;
    logic [19:0]        i_snp_sd = '0;
    logic [11:0]        i_read_individual = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [63:0] o_read_value;
    logic               o_is_read;
    int                 fail_count;
    int                 pending;

    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_cnt = 0;
    int quiet_cnt = 0;

    always #1 i_clk = ~i_clk;

    standardized_genotype_matvec_accum dut (.*);
    standardized_genotype_matvec_accum_checker checker_i (.*);

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_cnt  <= 400;
            i_ready   <= 1'b0;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
            i_ready  <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            quiet_cnt <= 0;
        else
            quiet_cnt <= quiet_cnt + 1;
        if (quiet_cnt == QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic reg_write(logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_COUNT, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_item(t_action act, logic [2:0] comp, logic [9:0] bidx,
                             logic [7:0] pbyte, logic [31:0] w, logic [17:0] mean,
                             logic [19:0] sd, logic [11:0] ridx);
        i_valid           <= 1'b1;
        i_action          <= act;
        i_component       <= comp;
        i_byte_index      <= bidx;
        i_packed_byte     <= pbyte;
        i_weight          <= w;
        i_snp_mean        <= mean;
        i_snp_sd          <= sd;
        i_read_individual <= ridx;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        while ($urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // lower valid and let every expected item come back
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    task automatic random_item();
        int          pick;
        t_action     act;
        logic [9:0]  bidx;
        logic [11:0] ridx;
        pick = $urandom_range(299);
        bidx = 10'($urandom_range(7));
        ridx = 12'($urandom_range(31));
        if (pick == 0)
            act = ACT_CLEAR;
        else if (pick < 10)
            act = ACT_NONE;
        else if (pick < 90)
            act = ACT_READ;
        else
            act = ACT_ACCUM;
        if ($urandom_range(9) == 0) begin
            bidx = 10'($urandom);
            ridx = 12'($urandom);
        end
        send_item(act, 3'($urandom), bidx, 8'($urandom), $urandom,
                  ($urandom_range(7) == 0) ? 18'($urandom) : 18'($urandom_range(131072)),
                  ($urandom_range(9) == 0) ? 20'd0 : 20'($urandom), ridx);
    endtask

    initial begin
        int gap_tab [4];
        int stall_tab [4];
        int count_tab [4];
        gap_tab   = '{0, 85, 0, 6};
        stall_tab = '{0, 0, 85, 6};
        count_tab = '{4096, 1, 37, 8191};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, every action, count limits
        send_item(ACT_ACCUM, 3'd0, 10'd0, 8'hE4, 32'h7FFF_FFFF, 18'd0, 20'd0, 12'd0);
        send_item(ACT_ACCUM, 3'd0, 10'd0, 8'hE4, 32'h8000_0000, 18'h3FFFF, 20'd1, 12'd0);
        send_item(ACT_ACCUM, 3'd7, 10'd1023, 8'h00, 32'h8000_0000, 18'd131072,
                  20'hFFFFF, 12'd0);
        send_item(ACT_ACCUM, 3'd7, 10'd1023, 8'hFF, 32'h7FFF_FFFF, 18'd65536, 20'd0, 12'd0);
        send_item(ACT_ACCUM, 3'd1, 10'd1, 8'hAA, 32'h4000_0000, 18'd32768, 20'd3, 12'd0);
        for (int k = 0; k < 4; k++)
            send_item(ACT_READ, 3'd0, 10'd0, 8'h00, 32'h0, 18'd0, 20'd0, 12'(k));
        send_item(ACT_READ, 3'd7, 10'd0, 8'h00, 32'h0, 18'd0, 20'd0, 12'd4095);
        send_item(ACT_READ, 3'd1, 10'd0, 8'h00, 32'h0, 18'd0, 20'd0, 12'd5);
        send_item(ACT_NONE, 3'd1, 10'd1, 8'hAA, 32'h4000_0000, 18'd0, 20'd0, 12'd5);
        send_item(ACT_READ, 3'd1, 10'd0, 8'h00, 32'h0, 18'd0, 20'd0, 12'd5);
        drain();
        reg_write(32'd6);
        send_item(ACT_ACCUM, 3'd2, 10'd1, 8'h55, 32'h1234_5678, 18'd100, 20'd70000, 12'd0);
        send_item(ACT_READ, 3'd2, 10'd0, 8'h00, 32'h0, 18'd0, 20'd0, 12'd5);
        send_item(ACT_READ, 3'd2, 10'd0, 8'h00, 32'h0, 18'd0, 20'd0, 12'd6);
        drain();
        reg_write(32'd0);
        send_item(ACT_ACCUM, 3'd2, 10'd0, 8'h00, 32'hDEAD_BEEF, 18'd5, 20'd9, 12'd0);
        send_item(ACT_READ, 3'd2, 10'd0, 8'h00, 32'h0, 18'd0, 20'd0, 12'd0);
        send_item(ACT_CLEAR, 3'd0, 10'd0, 8'h00, 32'h0, 18'd0, 20'd0, 12'd0);
        send_item(ACT_READ, 3'd0, 10'd0, 8'h00, 32'h0, 18'd0, 20'd0, 12'd0);

        for (int ph = 0; ph < 4; ph++) begin
            drain();
            reg_write(count_tab[ph]);
            send_gap_pct   = gap_tab[ph];
            recv_stall_pct = stall_tab[ph];
            for (int n = 0; n < 108; n++) begin
                if (ph == 0 && n == 20)
                    hold_req = hold_req + 1;
                if (n == 60)
                    drain();
                random_item();
            end
        end

        drain();
        repeat (200) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/sgm_pkg.sv
design/sgm_ctrl.sv
design/sgm_div.sv
design/sgm_dp.sv
design/standardized_genotype_matvec_accum.sv
design/sgm_checker.sv
verif/standardized_genotype_matvec_accum_checker.sv
verif/tb_standardized_genotype_matvec_accum.sv
